[src/ntwa_pkg.sv]
// package for the neighbor table with aging: codes, widths and the entry type
package ntwa_pkg;

    localparam int unsigned MaxNeighborsDef = 32;
    localparam int unsigned CoordBitsDef    = 24;
    localparam logic [15:0] AliveReset      = 16'd100;

    typedef enum logic [2:0] {
        CMD_TICK   = 3'd0,
        CMD_ADD    = 3'd1,
        CMD_DELETE = 3'd2,
        CMD_LOOKUP = 3'd3,
        CMD_READ   = 3'd4,
        CMD_CLEAR  = 3'd5,
        CMD_RSV6   = 3'd6,
        CMD_RSV7   = 3'd7
    } t_cmd;

    typedef enum logic [2:0] {
        ST_ADDED     = 3'd0,
        ST_UPDATED   = 3'd1,
        ST_DELETED   = 3'd2,
        ST_NOT_FOUND = 3'd3,
        ST_FOUND     = 3'd4,
        ST_FULL      = 3'd5,
        ST_CLEARED   = 3'd6,
        ST_TICK_DONE = 3'd7
    } t_status;

    // one table entry, coordinates always held at 24 bits
    typedef struct packed {
        logic [15:0]        addr;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [31:0]        stamp;
        logic [15:0]        life;
    } t_entry;

    // keep the low cbits bits and sign-extend to 24
    function automatic logic signed [23:0] to_coord(input logic signed [23:0] v,
                                                    input int unsigned cbits);
        logic signed [23:0] r;
        int unsigned b;
        b = (cbits < 24) ? cbits : 24;
        r = v;
        for (int i = 0; i < 24; i++) begin
            if (i >= int'(b)) r[i] = v[b-1];
        end
        return r;
    endfunction

endpackage

[src/ntwa_mem.sv]
// entry memory: one write port and one registered read port
module ntwa_mem #(
    parameter int unsigned DEPTH = ntwa_pkg::MaxNeighborsDef
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  ntwa_pkg::t_entry         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output ntwa_pkg::t_entry         o_rdata
);
    import ntwa_pkg::*;

    t_entry r_mem [DEPTH];
    t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[src/neighbor_table_with_aging_top.sv]
// neighbor table with aging: command sequencer over the entry memory
//
// channel | direction | handshake
// in      | input     | i_valid / o_stall
// out     | output    | o_valid / i_stall
// cfg     | input     | i_cfg_we / i_cfg_wdata (alive_ticks)
//
// each add, delete, lookup or tick is one sequential pass over the entry memory, one entry per
// cycle, behind the registered read port; a read fetches only the entry in its slot
// clear and unused commands skip the pass; the memory read port sets the pace
// reset is synchronous and empties the table and zeroes the time
// a finished result waits in the output register; the next item may be taken
// while it waits, but a second result holds the sequencer until the first leaves
module neighbor_table_with_aging_top
    import ntwa_pkg::*;
#(
    parameter int unsigned MAX_NEIGHBORS = MaxNeighborsDef,
    parameter int unsigned COORD_BITS    = CoordBitsDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [2:0]  i_cmd,
    input  logic [15:0] i_node_addr,
    input  logic signed [23:0] i_pos_x,
    input  logic signed [23:0] i_pos_y,
    input  logic signed [23:0] i_pos_z,
    input  logic [4:0]  i_slot,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [2:0]  o_status,
    output logic [15:0] o_out_addr,
    output logic signed [23:0] o_out_x,
    output logic signed [23:0] o_out_y,
    output logic signed [23:0] o_out_z,
    output logic [31:0] o_out_stamp,
    output logic [5:0]  o_entry_count,
    output logic [5:0]  o_expired_count
);
    localparam int unsigned AW = $clog2(MAX_NEIGHBORS);
    localparam int unsigned CW = $clog2(MAX_NEIGHBORS + 1);

    typedef enum logic [2:0] {S_IDLE, S_SCAN, S_SHIFT, S_DONE} t_state;

    t_state      r_state;
    t_cmd        r_cmd;
    logic [15:0] r_addr;
    logic signed [23:0] r_x, r_y, r_z;
    logic [4:0]  r_slot;
    logic [15:0] r_alive;
    logic [31:0] r_now;
    logic [CW-1:0] r_count;
    logic [CW-1:0] r_ridx;    // address issued to the read port
    logic [CW-1:0] r_cidx;    // index whose data is on the read port
    logic          r_rpend;   // read data valid this cycle
    logic [CW-1:0] r_widx;    // compaction write pointer
    logic [5:0]    r_expired;
    logic          r_found;
    t_entry        r_hit;
    logic [CW-1:0] r_hit_idx;

    logic          r_ovalid;
    logic [2:0]    r_o_status;
    logic [15:0]   r_o_addr;
    logic signed [23:0] r_o_x, r_o_y, r_o_z;
    logic [31:0]   r_o_stamp;
    logic [5:0]    r_o_count;
    logic [5:0]    r_o_expired;

    logic          mem_we;
    logic [AW-1:0] mem_waddr;
    t_entry        mem_wdata;
    t_entry        mem_rdata;
    logic          in_xfer;
    logic          out_xfer;
    t_entry        new_entry;
    logic          expired_now;

    ntwa_mem #(.DEPTH(MAX_NEIGHBORS)) u_mem (
        .i_clk  (i_clk),
        .i_we   (mem_we),
        .i_waddr(mem_waddr),
        .i_wdata(mem_wdata),
        .i_raddr(r_ridx[AW-1:0]),
        .o_rdata(mem_rdata)
    );

    assign o_stall  = (r_state != S_IDLE);
    assign in_xfer  = i_valid && !o_stall;
    assign out_xfer = r_ovalid && !i_stall;

    always_comb begin
        new_entry.addr  = r_addr;
        new_entry.x     = to_coord(r_x, COORD_BITS);
        new_entry.y     = to_coord(r_y, COORD_BITS);
        new_entry.z     = to_coord(r_z, COORD_BITS);
        new_entry.stamp = r_now;
        new_entry.life  = r_alive;
    end

    assign expired_now = ((r_now - mem_rdata.stamp) >= {16'd0, mem_rdata.life});

    // write port: compaction during tick and delete shift, store at done for add
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_widx[AW-1:0];
        mem_wdata = mem_rdata;
        if (r_state == S_SCAN && r_rpend && r_cmd == CMD_TICK && !expired_now) begin
            mem_we = (r_widx != r_cidx);
        end else if (r_state == S_SHIFT && r_rpend) begin
            mem_we    = 1'b1;
            mem_waddr = AW'(r_cidx - CW'(1));
        end else if (r_state == S_DONE && r_cmd == CMD_ADD
                     && (r_found || r_count < CW'(MAX_NEIGHBORS))) begin
            mem_we    = 1'b1;
            mem_waddr = r_found ? r_hit_idx[AW-1:0] : r_count[AW-1:0];
            mem_wdata = new_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_alive   <= AliveReset;
            r_now     <= '0;
            r_count   <= '0;
            r_ovalid  <= 1'b0;
            r_rpend   <= 1'b0;
        end else begin
            if (i_cfg_we) r_alive <= i_cfg_wdata;
            if (out_xfer) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    r_rpend <= 1'b0;
                    if (in_xfer) begin
                        r_cmd     <= t_cmd'(i_cmd);
                        r_addr    <= i_node_addr;
                        r_x       <= i_pos_x;
                        r_y       <= i_pos_y;
                        r_z       <= i_pos_z;
                        r_slot    <= i_slot;
                        r_ridx    <= '0;
                        r_widx    <= '0;
                        r_expired <= '0;
                        r_found   <= 1'b0;
                        if (t_cmd'(i_cmd) == CMD_TICK) r_now <= r_now + 32'd1;
                        if (t_cmd'(i_cmd) == CMD_READ) begin
                            r_ridx <= CW'(i_slot);
                            r_state <= S_SCAN;
                        end else if (t_cmd'(i_cmd) == CMD_CLEAR
                                     || t_cmd'(i_cmd) == CMD_RSV6
                                     || t_cmd'(i_cmd) == CMD_RSV7) begin
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_SCAN: begin
                    // issue reads front to back (a read fetches only its slot), examine data in the cycle after
                    if (r_cmd == CMD_READ) begin
                        if (r_rpend) begin
                            r_found <= (int'(r_slot) < int'(r_count))
                                       && (int'(r_slot) < int'(MAX_NEIGHBORS));
                            r_hit   <= mem_rdata;
                            r_rpend <= 1'b0;
                            r_state <= S_DONE;
                        end else begin
                            r_cidx  <= r_ridx;
                            r_rpend <= 1'b1;
                        end
                    end else begin
                        if (r_rpend) begin
                            if (r_cmd == CMD_TICK) begin
                                if (expired_now) r_expired <= r_expired + 6'd1;
                                else r_widx <= r_widx + CW'(1);
                            end else if (mem_rdata.addr == r_addr && !r_found) begin
                                r_found   <= 1'b1;
                                r_hit     <= mem_rdata;
                                r_hit_idx <= r_cidx;
                            end
                        end
                        if (r_rpend && r_cmd != CMD_TICK && mem_rdata.addr == r_addr
                            && !r_found) begin
                            // hit: delete moves on to shifting, others finish
                            r_rpend <= 1'b0;
                            if (r_cmd == CMD_DELETE) begin
                                r_ridx  <= r_cidx + CW'(1);
                                r_state <= S_SHIFT;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end else if (r_ridx < r_count) begin
                            r_cidx  <= r_ridx;
                            r_ridx  <= r_ridx + CW'(1);
                            r_rpend <= 1'b1;
                        end else begin
                            r_rpend <= 1'b0;
                            if (!r_rpend) r_state <= S_DONE;
                        end
                    end
                end
                S_SHIFT: begin
                    // entry i+1 moves to i; write happens on the read data
                    if (r_ridx < r_count) begin
                        r_cidx  <= r_ridx;
                        r_ridx  <= r_ridx + CW'(1);
                        r_rpend <= 1'b1;
                    end else begin
                        r_rpend <= 1'b0;
                        if (!r_rpend) r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    if (!r_ovalid || out_xfer) begin
                        r_ovalid    <= 1'b1;
                        r_o_addr    <= '0;
                        r_o_x       <= '0;
                        r_o_y       <= '0;
                        r_o_z       <= '0;
                        r_o_stamp   <= '0;
                        r_o_expired <= '0;
                        r_o_status  <= ST_NOT_FOUND;
                        r_o_count   <= 6'(r_count);
                        case (r_cmd) inside
                            CMD_TICK: begin
                                r_o_status  <= ST_TICK_DONE;
                                r_o_expired <= r_expired;
                                r_o_count   <= 6'(r_widx);
                                r_count     <= r_widx;
                            end
                            CMD_ADD: begin
                                r_o_addr <= r_addr;
                                if (r_found) begin
                                    r_o_status <= ST_UPDATED;
                                end else if (r_count >= CW'(MAX_NEIGHBORS)) begin
                                    r_o_status <= ST_FULL;
                                end else begin
                                    r_o_status <= ST_ADDED;
                                    r_count    <= r_count + CW'(1);
                                    r_o_count  <= 6'(r_count + CW'(1));
                                end
                            end
                            CMD_DELETE: begin
                                if (r_found) begin
                                    r_o_status <= ST_DELETED;
                                    r_o_addr   <= r_addr;
                                    r_count    <= r_count - CW'(1);
                                    r_o_count  <= 6'(r_count - CW'(1));
                                end
                            end
                            CMD_LOOKUP, CMD_READ: begin
                                if (r_found) begin
                                    r_o_status <= ST_FOUND;
                                    r_o_addr   <= r_hit.addr;
                                    r_o_x      <= r_hit.x;
                                    r_o_y      <= r_hit.y;
                                    r_o_z      <= r_hit.z;
                                    r_o_stamp  <= r_hit.stamp;
                                end
                            end
                            CMD_CLEAR: begin
                                r_o_status <= ST_CLEARED;
                                r_count    <= '0;
                                r_o_count  <= '0;
                            end
                            default: ;
                        endcase
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid         = r_ovalid;
    assign o_status        = r_o_status;
    assign o_out_addr      = r_o_addr;
    assign o_out_x         = r_o_x;
    assign o_out_y         = r_o_y;
    assign o_out_z         = r_o_z;
    assign o_out_stamp     = r_o_stamp;
    assign o_entry_count   = r_o_count;
    assign o_expired_count = r_o_expired;
endmodule

[src/ntwa_checker.sv]
// port-level checks for the neighbor table, bound to the top level
module ntwa_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_stall,
    input logic        o_valid,
    input logic        i_stall,
    input logic [2:0]  o_status,
    input logic [5:0]  o_entry_count,
    input logic [5:0]  o_expired_count
);
    import ntwa_pkg::*;

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_status))
        else $error("result changed while stalled");

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_entry_count <= 6'(MaxNeighborsDef))
        else $error("entry count beyond capacity");

    a_expired_only_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status != ST_TICK_DONE |-> o_expired_count == 6'd0)
        else $error("expired count outside tick");

    a_clear_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_CLEARED |-> o_entry_count == 6'd0)
        else $error("clear left entries");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid && !o_stall)
        else $error("not idle after reset");
endmodule

bind neighbor_table_with_aging_top ntwa_checker u_ntwa_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_status       (o_status),
    .o_entry_count  (o_entry_count),
    .o_expired_count(o_expired_count)
);

[tb/tb_neighbor_table_with_aging_top.sv]
// self-checking testbench for the neighbor table with aging
module tb_neighbor_table_with_aging_top;
    import ntwa_pkg::*;

    typedef struct packed {
        logic [2:0]         status;
        logic [15:0]        addr;
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic [31:0]        stamp;
        logic [5:0]         count;
        logic [5:0]         expired;
    } t_answer;

    class table_scoreboard;
        t_entry      rows[32];
        int unsigned used;
        logic [31:0] now;
        logic [15:0] life;
        t_answer     pending[$];
        int          errors;

        function new();
            used = 0;
            now = 0;
            life = AliveReset;
            errors = 0;
        endfunction

        function int find(logic [15:0] a);
            for (int i = 0; i < used; i++) if (rows[i].addr == a) return i;
            return -1;
        endfunction

        function void note_command(logic [2:0] cmd, logic [15:0] a, logic signed [23:0] px,
                                   logic signed [23:0] py, logic signed [23:0] pz,
                                   logic [4:0] slot);
            t_answer r;
            t_entry e;
            int k;
            int unsigned w;
            r = '0;
            r.status = ST_NOT_FOUND;
            e.addr = a; e.x = px; e.y = py; e.z = pz; e.stamp = now; e.life = life;
            case (cmd)
                CMD_TICK: begin
                    now = now + 1;
                    w = 0;
                    for (int i = 0; i < used; i++) begin
                        if (32'(now - rows[i].stamp) >= 32'(rows[i].life)) r.expired++;
                        else begin
                            rows[w] = rows[i];
                            w++;
                        end
                    end
                    used = w;
                    r.status = ST_TICK_DONE;
                end
                CMD_ADD: begin
                    k = find(a);
                    r.addr = a;
                    e.stamp = now;
                    if (k >= 0) begin
                        rows[k] = e;
                        r.status = ST_UPDATED;
                    end else if (used >= 32) r.status = ST_FULL;
                    else begin
                        rows[used] = e;
                        used++;
                        r.status = ST_ADDED;
                    end
                end
                CMD_DELETE: begin
                    k = find(a);
                    if (k >= 0) begin
                        for (int i = k; i + 1 < used; i++) rows[i] = rows[i+1];
                        used--;
                        r.status = ST_DELETED;
                        r.addr = a;
                    end
                end
                CMD_LOOKUP, CMD_READ: begin
                    k = (cmd == CMD_LOOKUP) ? find(a) : ((slot < used) ? int'(slot) : -1);
                    if (k >= 0) begin
                        r.status = ST_FOUND;
                        r.addr = rows[k].addr;
                        r.x = rows[k].x; r.y = rows[k].y; r.z = rows[k].z;
                        r.stamp = rows[k].stamp;
                    end
                end
                CMD_CLEAR: begin
                    used = 0;
                    r.status = ST_CLEARED;
                end
                default: ;
            endcase
            r.count = 6'(used);
            pending = {pending, r};
        endfunction

        function t_answer take_oldest(output bit ok);
            ok = pending.size() > 0;
            if (ok) return pending.pop_front();
            return '0;
        endfunction
    endclass

    logic        i_clk = 0;
    logic        i_rst_n = 0;
    logic        i_valid = 0;
    logic        o_stall;
    logic [2:0]  i_cmd = 0;
    logic [15:0] i_node_addr = 0;
    logic signed [23:0] i_pos_x = 0, i_pos_y = 0, i_pos_z = 0;
    logic [4:0]  i_slot = 0;
    logic        i_cfg_we = 0;
    logic [15:0] i_cfg_wdata = 0;
    logic        o_valid;
    logic        i_stall = 0;
    logic [2:0]  o_status;
    logic [15:0] o_out_addr;
    logic signed [23:0] o_out_x, o_out_y, o_out_z;
    logic [31:0] o_out_stamp;
    logic [5:0]  o_entry_count, o_expired_count;

    table_scoreboard sb = new();
    bit quiet = 0;
    bit hold_off = 0;
    int idle_cycles = 0;
    logic [15:0] addr_pool[8];

    neighbor_table_with_aging_top dut (.*);

    always begin
        #5 i_clk = 1;
        #5 i_clk = 0;
    end

    task automatic report_mismatch(string what, longint got, longint want);
        $display("mismatch %s: got %0h want %0h", what, got, want);
        sb.errors++;
    endtask

    // result side: compare every output transfer
    always @(posedge i_clk) begin
        t_answer w;
        bit ok;
        if (i_rst_n && o_valid && !i_stall) begin
            w = sb.take_oldest(ok);
            if (!ok) report_mismatch("unexpected result", o_status, 0);
            else begin
                if (o_status != w.status) report_mismatch("status", o_status, w.status);
                if (o_out_addr != w.addr) report_mismatch("addr", o_out_addr, w.addr);
                if (o_out_x != w.x) report_mismatch("x", o_out_x, w.x);
                if (o_out_y != w.y) report_mismatch("y", o_out_y, w.y);
                if (o_out_z != w.z) report_mismatch("z", o_out_z, w.z);
                if (o_out_stamp != w.stamp) report_mismatch("stamp", o_out_stamp, w.stamp);
                if (o_entry_count != w.count) report_mismatch("count", o_entry_count, w.count);
                if (o_expired_count != w.expired)
                    report_mismatch("expired", o_expired_count, w.expired);
            end
        end
    end

    // receiver stalls in random bursts, or holds off for a long stretch
    always @(posedge i_clk) begin
        int n;
        if (hold_off) begin
            i_stall <= 1;
            repeat (300) @(posedge i_clk);
            hold_off = 0;
            i_stall <= 0;
        end else if (!quiet && $urandom_range(0, 5) == 0) begin
            n = $urandom_range(1, 4);
            i_stall <= 1;
            repeat (n) @(posedge i_clk);
            i_stall <= 0;
        end
    end

    // watchdog on cycles with no transfer
    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) idle_cycles = 0;
        else idle_cycles++;
        if (idle_cycles > 3000) begin
            $display("end of test: mismatches");
            $finish;
        end
    end

    task automatic send(logic [2:0] cmd, logic [15:0] a, logic signed [23:0] px,
                        logic signed [23:0] py, logic signed [23:0] pz, logic [4:0] slot);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            i_valid <= 0;
            repeat ($urandom_range(1, 4)) @(posedge i_clk);
        end
        i_valid <= 1;
        i_cmd <= cmd; i_node_addr <= a; i_pos_x <= px; i_pos_y <= py; i_pos_z <= pz;
        i_slot <= slot;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sb.note_command(cmd, a, px, py, pz, slot);
    endtask

    task automatic drain();
        i_valid <= 0;
        @(posedge i_clk);
        while (sb.pending.size() > 0) @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_life(logic [15:0] v);
        drain();
        i_cfg_we <= 1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we <= 0;
        sb.life = v;
    endtask

    task automatic random_item(int bias);
        logic [2:0] c;
        logic [15:0] a;
        int r;
        r = $urandom_range(0, 99);
        if (r < 40) c = CMD_ADD;
        else if (r < 55) c = CMD_TICK;
        else if (r < 67) c = CMD_DELETE;
        else if (r < 80) c = CMD_LOOKUP;
        else if (r < 92) c = CMD_READ;
        else if (r < 95 - bias) c = CMD_CLEAR;
        else c = 3'($urandom_range(6, 7));
        a = ($urandom_range(0, 3) == 0) ? 16'($urandom) : addr_pool[$urandom_range(0, 7)];
        send(c, a, 24'($urandom), 24'($urandom), 24'($urandom), 5'($urandom));
    endtask

    initial begin
        logic [15:0] lifes[6];
        lifes = '{16'd1, 16'd3, 16'd65535, 16'd10, 16'd40, 16'd2};
        for (int i = 0; i < 8; i++) addr_pool[i] = 16'($urandom);
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);
        // directed: extremes, every command, full table, misses
        send(CMD_LOOKUP, 16'h0000, 0, 0, 0, 0);
        send(CMD_READ, 0, 0, 0, 0, 5'd31);
        send(CMD_DELETE, 16'hffff, 0, 0, 0, 0);
        send(CMD_ADD, 16'h0000, 24'sh7fffff, -24'sd8388608, 24'sh0, 0);
        send(CMD_ADD, 16'hffff, -24'sd1, 24'sh7fffff, -24'sd8388608, 0);
        send(CMD_ADD, 16'h0000, 24'sh1, 24'sh2, 24'sh3, 0);
        send(CMD_LOOKUP, 16'h0000, 0, 0, 0, 0);
        send(CMD_READ, 0, 0, 0, 0, 5'd1);
        send(CMD_TICK, 0, 0, 0, 0, 0);
        send(CMD_DELETE, 16'h0000, 0, 0, 0, 0);
        send(CMD_RSV6, 0, 0, 0, 0, 0);
        send(CMD_RSV7, 16'hffff, 0, 0, 0, 5'd31);
        for (int i = 0; i < 33; i++) send(CMD_ADD, 16'(i * 7 + 1), 24'(i), 0, 0, 0);
        send(CMD_READ, 0, 0, 0, 0, 5'd31);
        send(CMD_CLEAR, 0, 0, 0, 0, 0);
        set_life(16'd0);
        send(CMD_ADD, 16'h1234, 0, 0, 0, 0);
        send(CMD_TICK, 0, 0, 0, 0, 0);
        // receiver holds off while the sender keeps offering
        hold_off = 1;
        for (int i = 0; i < 10; i++) random_item(0);
        for (int p = 0; p < 6; p++) begin
            set_life(lifes[p]);
            if (p == 5) quiet = 1;
            for (int i = 0; i < 250; i++) random_item(p % 2 ? 3 : 0);
        end
        drain();
        if (sb.errors == 0 && sb.pending.size() == 0) $display("end of test: clean");
        else $display("end of test: mismatches");
        $finish;
    end
endmodule
